[src/cbvg_pkg.sv]
// shared types, constants and helper functions for the cone-beam view geometry block
package cbvg_pkg;

  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_NEG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_DIST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HELIX_PITCH = 3'd4;

  localparam logic [19:0] TWO_PI_Q16  = 20'd411775;
  localparam logic [19:0] PI_Q16      = 20'd205887;
  localparam logic [19:0] HALF_PI_Q16 = 20'd102944;
  // 2^31 mod 2*pi, undoes the offset-binary view of the angle
  localparam logic [19:0] OFFSET_MOD  = 20'd77023;
  localparam int unsigned RECIP_SHIFT = 44;
  localparam logic [25:0] RECIP       = 26'((64'd1 << RECIP_SHIFT) / 64'd411775);

  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic        op;
    logic [15:0] proj_index;
    logic [31:0] given_angle;
  } in_item_t;

  typedef struct packed {
    logic [31:0] view_angle;
    logic [15:0] row_dir_x;
    logic [15:0] row_dir_y;
    logic [15:0] ray_dir_x;
    logic [15:0] ray_dir_y;
    logic [31:0] source_x;
    logic [31:0] source_y;
    logic [31:0] source_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic signed [31:0] start_angle;
    logic signed [31:0] angle_step;
    logic               rotate_negative;
    logic [30:0]        source_iso_distance;
    logic signed [31:0] helix_pitch;
  } cfg_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW:0]   t;
    logic signed [CW-16:0] r;
    logic signed [15:0]   o;
    t = {v[CW-1], v} + (CW+1)'(32768);
    r = t[CW:16];
    if (r > (CW-15)'(16384)) o = ONE_Q14;
    else if (r < -(CW-15)'(16384)) o = -ONE_Q14;
    else o = r[15:0];
    return o;
  endfunction

endpackage

[src/cbvg_angle.sv]
// angle formation and reduction into the cordic range
module cbvg_angle
  import cbvg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  in_item_t             in_item,
  input  cfg_t                 cfg,
  output logic                 out_v,
  output logic signed [CW-1:0] z,
  output side_t                side
);

  logic [5:0] v;

  // stage 1: index product
  logic               op1;
  logic signed [31:0] given1;
  logic signed [48:0] prod1;
  // stage 2: saturated angle
  logic signed [31:0] angle2;
  // stage 3: reciprocal product
  logic signed [31:0] angle3;
  logic [31:0]        u3;
  logic [57:0]        qp3;
  // stage 4: coarse remainder
  logic signed [31:0] angle4;
  logic [19:0]        r4;
  // stage 5: floor modulo
  logic signed [31:0] angle5;
  logic [18:0]        r5;

  logic signed [49:0] sum2;
  logic [31:0]        u;
  logic [13:0]        q;
  logic [32:0]        qp;
  logic [19:0]        r1;
  logic signed [20:0] t5;
  logic signed [20:0] rs;
  logic signed [20:0] rf;
  logic               negf;

  always_comb begin
    sum2 = 50'(cfg.start_angle) + 50'(prod1);
    u    = {~angle2[31], angle2[30:0]};
    q    = qp3[57:RECIP_SHIFT];
    qp   = 33'(q) * 33'(TWO_PI_Q16);
    r1   = (r4 >= TWO_PI_Q16) ? r4 - TWO_PI_Q16 : r4;
    t5   = $signed({1'b0, r1}) - $signed({1'b0, OFFSET_MOD});
    rs   = ({2'b0, r5} > {1'b0, PI_Q16}) ? $signed({2'b0, r5}) - $signed({1'b0, TWO_PI_Q16})
                                         : $signed({2'b0, r5});
    negf = 1'b0;
    rf   = rs;
    if (rs > $signed({1'b0, HALF_PI_Q16})) begin
      rf   = rs - $signed({1'b0, PI_Q16});
      negf = 1'b1;
    end else if (rs < -$signed({1'b0, HALF_PI_Q16})) begin
      rf   = rs + $signed({1'b0, PI_Q16});
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_v};
    end
    if (en) begin
      op1    <= in_item.op;
      given1 <= in_item.given_angle;
      prod1  <= cfg.angle_step * $signed({1'b0, in_item.proj_index});
      angle2 <= op1 ? given1 : sat32(66'(sum2));
      angle3 <= angle2;
      u3     <= u;
      qp3    <= 58'(u) * 58'(RECIP);
      angle4 <= angle3;
      r4     <= 20'(u3 - qp[31:0]);
      angle5 <= angle4;
      r5     <= (t5 < 0) ? 19'(t5 + $signed({1'b0, TWO_PI_Q16})) : 19'(t5);
      side.angle <= angle5;
      side.neg   <= negf;
      z          <= CW'(rf) <<< 14;
    end
  end

  assign out_v = v[5];

endmodule

[src/cbvg_cordic.sv]
// pipelined rotation-mode cordic, one iteration per stage
module cbvg_cordic
  import cbvg_pkg::*;
#(
  parameter int unsigned STEPS = 16
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CW-1:0] z_in,
  input  side_t                side_in,
  output logic                 out_v,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output side_t                side_out
);

  localparam int unsigned N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

  logic                 v  [0:N];
  logic signed [CW-1:0] x  [0:N];
  logic signed [CW-1:0] y  [0:N];
  logic signed [CW-1:0] z  [0:N];
  side_t                sd [0:N];

  assign v[0]  = in_v;
  assign x[0]  = CORDIC_GAIN;
  assign y[0]  = '0;
  assign z[0]  = z_in;
  assign sd[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        sd[i+1] <= sd[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q30(i);
        end
      end
    end
  end

  assign out_v    = v[N];
  assign x_out    = x[N];
  assign y_out    = y[N];
  assign side_out = sd[N];

endmodule

[src/cbvg_output.sv]
// direction rounding, source position products and the output register
module cbvg_output
  import cbvg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  side_t                side_in,
  input  cfg_t                 cfg,
  output logic                 out_v,
  output out_item_t            out_item
);

  logic [1:0] v;

  logic signed [31:0] angle1;
  logic signed [15:0] c1;
  logic signed [15:0] s1;
  logic signed [63:0] pz1;

  logic signed [31:0] angle2;
  logic signed [15:0] c2;
  logic signed [15:0] s2;
  logic signed [47:0] px2;
  logic signed [47:0] py2;
  logic signed [65:0] nz2;

  logic signed [15:0] cq;
  logic signed [15:0] sq;
  logic signed [48:0] rx;
  logic signed [48:0] ry;

  always_comb begin
    cq = to_q14(x_in);
    sq = to_q14(y_in);
    if (side_in.neg) begin
      cq = -cq;
      sq = -sq;
    end
    if (cfg.rotate_negative) sq = -sq;
    rx = 49'(px2) + 49'sd8192;
    ry = 49'(py2) + 49'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v     <= {v[0], in_v};
      out_v <= v[1];
    end
    if (en) begin
      angle1 <= side_in.angle;
      c1     <= cq;
      s1     <= sq;
      pz1    <= cfg.helix_pitch * side_in.angle;
      angle2 <= angle1;
      c2     <= c1;
      s2     <= s1;
      px2    <= $signed({1'b0, cfg.source_iso_distance}) * c1;
      py2    <= $signed({1'b0, cfg.source_iso_distance}) * s1;
      nz2    <= 66'sd32768 - 66'(pz1);
      out_item.view_angle <= angle2;
      out_item.row_dir_x  <= -s2;
      out_item.row_dir_y  <= c2;
      out_item.ray_dir_x  <= -c2;
      out_item.ray_dir_y  <= -s2;
      out_item.source_x   <= sat32(66'(rx >>> 14));
      out_item.source_y   <= sat32(66'(ry >>> 14));
      out_item.source_z   <= sat32(nz2 >>> 16);
    end
  end

endmodule

[src/cone_beam_view_geometry.sv]
// top level of the cone-beam view geometry block
// each accepted item passes the angle, cordic and output stages in turn before its result is valid
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// the cordic stage count, capped at 24, sets the depth of the pipeline
// reset clears all valid bits and the configuration registers to zero
// configuration writes are always taken, ready is tied high
module cone_beam_view_geometry
  import cbvg_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;
  logic en;

  logic                 a_v;
  logic signed [CW-1:0] a_z;
  side_t                a_side;
  logic                 c_v;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  side_t                c_side;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_ANGLE: cfg.start_angle         <= cfg_data;
        CFG_ANGLE_STEP:  cfg.angle_step          <= cfg_data;
        CFG_ROTATE_NEG:  cfg.rotate_negative     <= cfg_data[0];
        CFG_SRC_DIST:    cfg.source_iso_distance <= cfg_data[30:0];
        CFG_HELIX_PITCH: cfg.helix_pitch         <= cfg_data;
        default: ;
      endcase
    end
  end

  cbvg_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (in_valid),
    .in_item (in_data),
    .cfg     (cfg),
    .out_v   (a_v),
    .z       (a_z),
    .side    (a_side)
  );

  cbvg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (a_v),
    .z_in     (a_z),
    .side_in  (a_side),
    .out_v    (c_v),
    .x_out    (c_x),
    .y_out    (c_y),
    .side_out (c_side)
  );

  cbvg_output u_output (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (c_v),
    .x_in     (c_x),
    .y_in     (c_y),
    .side_in  (c_side),
    .cfg      (cfg),
    .out_v    (out_valid),
    .out_item (out_data)
  );

endmodule

[src/cbvg_checker.sv]
// port-level checks for the cone-beam view geometry block
module cbvg_checker
  import cbvg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input side stalls exactly when the result is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // row x and ray y are both minus the signed sine
  a_sine: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.row_dir_x == out_data.ray_dir_y)
    else $error("sine terms disagree");

  // ray x is the negated row y
  a_cos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_data.ray_dir_x) == -$signed(out_data.row_dir_y))
    else $error("cosine terms disagree");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_data.row_dir_y) <= 16'sd16384 &&
                  $signed(out_data.row_dir_y) >= -16'sd16384)
    else $error("cosine out of range");

endmodule

bind cone_beam_view_geometry cbvg_checker u_cbvg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/cone_beam_view_geometry_test.sv]
// self-checking testbench for the cone-beam view geometry block
module cone_beam_view_geometry_test;
  import cbvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = STEPS + 9;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam longint TWO_PI = 411775;
  localparam longint PI = 205887;
  localparam longint HALF_PI = 102944;
  localparam longint GAIN = 652032874;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  class view_scoreboard;
    longint start_angle, angle_step, src_dist, pitch;
    bit rotate_neg;
    out_item_t pending[$];
    int errors, seen_in, seen_out;
    longint atan_tab[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127};

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_START_ANGLE: start_angle = longint'($signed(d));
        CFG_ANGLE_STEP:  angle_step = longint'($signed(d));
        CFG_ROTATE_NEG:  rotate_neg = d[0];
        CFG_SRC_DIST:    src_dist = longint'({33'b0, d[30:0]});
        CFG_HELIX_PITCH: pitch = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
    endfunction

    function longint q30_to_q14(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
    endfunction

    function void note_input(in_item_t it);
      longint ang, r, x, y, z, dx, dy, c, s, sx, sy, sz;
      bit flip;
      out_item_t e;
      if (it.op == 1'b0)
        ang = clamp32(start_angle + angle_step * longint'({48'b0, it.proj_index}));
      else
        ang = longint'($signed(it.given_angle));
      // fold into +-pi/2, remember whether to negate
      r = ang % TWO_PI;
      flip = 0;
      if (r < 0) r += TWO_PI;
      if (r > PI) r -= TWO_PI;
      if (r > HALF_PI) begin
        r -= PI;
        flip = 1;
      end else if (r < -HALF_PI) begin
        r += PI;
        flip = 1;
      end
      x = GAIN;
      y = 0;
      z = r * 16384;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c = q30_to_q14(x);
      s = q30_to_q14(y);
      if (flip) begin
        c = -c; s = -s;
      end
      if (rotate_neg) s = -s;
      sx = clamp32((src_dist * c + 8192) >>> 14);
      sy = clamp32((src_dist * s + 8192) >>> 14);
      sz = clamp32((-(pitch * ang) + 32768) >>> 16);
      e.view_angle = ang[31:0];
      e.row_dir_x = 16'(-s);
      e.row_dir_y = c[15:0];
      e.ray_dir_x = 16'(-c);
      e.ray_dir_y = 16'(-s);
      e.source_x = sx[31:0];
      e.source_y = sy[31:0];
      e.source_z = sz[31:0];
      pending.push_back(e);
      seen_in++;
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s expected %h actual %h", $realtime, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      seen_out++;
      if (pending.size() == 0) begin
        $display("%0t unexpected item expected none actual %h", $realtime, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("view_angle", e.view_angle, a.view_angle);
      cmp("row_dir_x", e.row_dir_x, a.row_dir_x);
      cmp("row_dir_y", e.row_dir_y, a.row_dir_y);
      cmp("ray_dir_x", e.ray_dir_x, a.ray_dir_x);
      cmp("ray_dir_y", e.ray_dir_y, a.ray_dir_y);
      cmp("source_x", e.source_x, a.source_x);
      cmp("source_y", e.source_y, a.source_y);
      cmp("source_z", e.source_z, a.source_z);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  view_scoreboard sb = new();
  idle_mode_e mode = IDLE_NONE;
  int idle_cycles = 0;
  int cfg_writes = 0;

  cone_beam_view_geometry #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (mode == IDLE_RECEIVER) out_stall <= ($urandom_range(99) < 77);
    else if (mode == IDLE_BOTH) out_stall <= ($urandom_range(99) < 15);
    else out_stall <= 1'b0;
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_view(logic op, logic [15:0] idx, logic [31:0] ang);
    in_item_t it;
    it.op = op;
    it.proj_index = idx;
    it.given_angle = ang;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if ((mode == IDLE_SENDER && $urandom_range(99) < 77) ||
        (mode == IDLE_BOTH && $urandom_range(99) < 15)) begin
      in_valid <= 1'b0;
      in_data <= '0;
      do @(posedge clk);
      while ((mode == IDLE_SENDER && $urandom_range(99) < 77) ||
             (mode == IDLE_BOTH && $urandom_range(99) < 15));
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(800000)) - 400000);
      3: return 32'($signed($urandom_range(4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config;
    write_cfg(CFG_START_ANGLE, pick32());
    write_cfg(CFG_ANGLE_STEP, ($urandom_range(2) == 0) ? pick32() :
              32'($signed($urandom_range(2000)) - 1000));
    write_cfg(CFG_ROTATE_NEG, $urandom);
    write_cfg(CFG_SRC_DIST, ($urandom_range(3) == 0) ? 32'hffffffff : $urandom);
    write_cfg(CFG_HELIX_PITCH, pick32());
  endtask

  initial begin
    logic [31:0] ang;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration
    send_view(1'b0, 16'd0, 32'd0);
    send_view(1'b1, 16'hffff, 32'h0001_0000);
    drain();

    // extreme configuration, saturating index angle and products
    write_cfg(CFG_START_ANGLE, 32'h7fffffff);
    write_cfg(CFG_ANGLE_STEP, 32'h7fffffff);
    write_cfg(CFG_ROTATE_NEG, 32'hffffffff);
    write_cfg(CFG_SRC_DIST, 32'hffffffff);
    write_cfg(CFG_HELIX_PITCH, 32'h80000000);
    write_cfg(CFG_UNUSED, 32'hdeadbeef);
    send_view(1'b0, 16'd0, 32'd0);
    send_view(1'b0, 16'hffff, 32'hffffffff);
    send_view(1'b1, 16'd0, 32'h7fffffff);
    send_view(1'b1, 16'd0, 32'h80000000);
    send_view(1'b1, 16'd0, 32'd0);
    send_view(1'b1, 16'd0, 32'd205887);
    send_view(1'b1, 16'd0, 32'd205888);
    send_view(1'b1, 16'd0, -32'sd205887);
    send_view(1'b1, 16'd0, 32'd102944);
    send_view(1'b1, 16'd0, 32'd102945);
    send_view(1'b1, 16'd0, -32'sd102944);
    send_view(1'b1, 16'd0, -32'sd102945);
    send_view(1'b1, 16'd0, 32'd411775);
    send_view(1'b1, 16'd0, -32'sd411775);
    send_view(1'b1, 16'd0, 32'd411774);
    drain();
    write_cfg(CFG_START_ANGLE, 32'h80000000);
    write_cfg(CFG_ANGLE_STEP, 32'h80000000);
    write_cfg(CFG_ROTATE_NEG, 32'h0);
    write_cfg(CFG_SRC_DIST, 32'h7fffffff);
    write_cfg(CFG_HELIX_PITCH, 32'h7fffffff);
    send_view(1'b0, 16'hffff, 32'd0);
    send_view(1'b0, 16'd1, 32'd0);
    send_view(1'b1, 16'd0, 32'h80000000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(2))
          0: ang = $urandom;
          1: ang = 32'($signed($urandom_range(3294200)) - 1647100);
          default: ang = 32'($signed($urandom_range(400)) - 200);
        endcase
        send_view(1'($urandom_range(1)), 16'($urandom), ang);
      end
      drain();
      mode = IDLE_NONE;
    end

    if (sb.pending.size() != 0) begin
      $display("%0t %0d expected items never arrived", $realtime, sb.pending.size());
      sb.errors++;
    end
    $display("views sent %0d, results checked %0d, register writes %0d",
             sb.seen_in, sb.seen_out, cfg_writes);
    $display("covered saturating configs, angle fold edges and four handshake pacings");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
